@@ rtl/lfra_pkg.sv @@
// ----------------------------------------------------------------------------
// lfra_pkg: shared types and constants
// Field widths, queue sizing and the booking request type for the
// lowest free room allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package lfra_pkg;

  localparam int IN_TIME_W   = 32;
  localparam int OUT_TIME_W  = 48;
  localparam int CNT_W       = 32;
  localparam int ROOM_W      = 4;
  localparam int CFG_W       = 5;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_W-1:0] NUM_ROOMS_RST = 5'd16;

  typedef struct packed {
    logic [IN_TIME_W-1:0] start_time;
    logic [IN_TIME_W-1:0] dur;
    logic                 new_set;
  } lfra_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lfra_qstat_t;

endpackage

`default_nettype wire

@@ rtl/lfra_if.sv @@
// ----------------------------------------------------------------------------
// lfra_if: channel interfaces
// Valid/ready channels for booking requests, results and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfra_in_if import lfra_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [IN_TIME_W-1:0] start_time;
  logic [IN_TIME_W-1:0] end_time;
  logic                 new_set;

  modport source(output valid, start_time, end_time, new_set, input ready);
  modport sink(input valid, start_time, end_time, new_set, output ready);
endinterface

interface lfra_out_if import lfra_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [ROOM_W-1:0]     room;
  logic [OUT_TIME_W-1:0] actual_start;
  logic [OUT_TIME_W-1:0] actual_end;
  logic [ROOM_W-1:0]     most_booked_room;
  logic [CNT_W-1:0]      most_booked_count;

  modport source(output valid, room, actual_start, actual_end, most_booked_room,
                 most_booked_count, input ready);
  modport sink(input valid, room, actual_start, actual_end, most_booked_room,
               most_booked_count, output ready);
endinterface

interface lfra_cfg_if import lfra_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] num_rooms;

  modport source(output valid, num_rooms, input ready);
  modport sink(input valid, num_rooms, output ready);
endinterface

`default_nettype wire

@@ rtl/lfra_queue.sv @@
// ----------------------------------------------------------------------------
// lfra_queue: request queue
// Short FIFO of classified requests between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module lfra_queue import lfra_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  lfra_req_t   push_data,
  input  logic        pop,
  output lfra_req_t   head,
  output lfra_qstat_t stat
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  lfra_req_t       slot_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   count_nxt;
  logic            do_push;
  logic            do_pop;

  assign stat.full  = (count_r == CW'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/lfra_front.sv @@
// ----------------------------------------------------------------------------
// lfra_front: request front end
// Accepts booking items, derives the duration and pushes them to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lfra_front import lfra_pkg::*; (
  lfra_in_if.sink     in_chan,
  input  lfra_qstat_t q_stat,
  output logic        push,
  output lfra_req_t   req
);

  assign in_chan.ready  = !q_stat.full;
  assign push           = in_chan.valid && !q_stat.full;
  assign req.start_time = in_chan.start_time;
  assign req.new_set    = in_chan.new_set;
  // clamp to zero when end does not follow start
  assign req.dur        = (in_chan.end_time > in_chan.start_time) ?
                          (in_chan.end_time - in_chan.start_time) : '0;

endmodule

`default_nettype wire

@@ rtl/lfra_back.sv @@
// ----------------------------------------------------------------------------
// lfra_back: allocation back end
// Scans room state one room per cycle, picks a room, updates the free time
// and use count, and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lfra_back import lfra_pkg::*; #(
  parameter int ROOMS     = 16,
  parameter int TIME_BITS = 48
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CFG_W-1:0] num_rooms,
  input  lfra_req_t        head,
  input  lfra_qstat_t      q_stat,
  output logic             pop,
  lfra_out_if.source       out_chan
);

  localparam int RW = (ROOMS > 1) ? $clog2(ROOMS) : 1;
  localparam int NW = $clog2(ROOMS + 1);
  localparam int SW = TIME_BITS + 1;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
  localparam logic [CNT_W-1:0]     CNT_MAX  = '1;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_FIN} state_t;

  state_t                state_r;
  logic [TIME_BITS-1:0]  free_mem [ROOMS];
  logic [CNT_W-1:0]      cnt_mem [ROOMS];
  logic [TIME_BITS-1:0]  rd_free_r;
  logic [CNT_W-1:0]      rd_cnt_r;
  logic [ROOMS-1:0]      vld_r;
  logic [TIME_BITS-1:0]  clock_now_r;
  logic [TIME_BITS-1:0]  t_r;
  logic [TIME_BITS-1:0]  min_r;
  logic [IN_TIME_W-1:0]  dur_r;
  logic [NW-1:0]         n_r;
  logic [NW-1:0]         iss_r;
  logic                  dv_r;
  logic [RW-1:0]         didx_r;
  logic                  found_r;
  logic [RW-1:0]         pick_r;
  logic [RW-1:0]         min_idx_r;
  logic [RW-1:0]         best_idx_r;
  logic [CNT_W-1:0]      pick_cnt_r;
  logic [CNT_W-1:0]      min_cnt_r;
  logic [CNT_W-1:0]      best_cnt_r;
  logic                  out_valid_r;
  logic [ROOM_W-1:0]     out_room_r;
  logic [OUT_TIME_W-1:0] out_start_r;
  logic [OUT_TIME_W-1:0] out_end_r;
  logic [ROOM_W-1:0]     out_best_room_r;
  logic [CNT_W-1:0]      out_best_cnt_r;

  logic [NW-1:0]         n_eff;
  logic [TIME_BITS-1:0]  clk_base;
  logic [TIME_BITS-1:0]  start_ext;
  logic [TIME_BITS-1:0]  t_start;
  logic [TIME_BITS-1:0]  cur_free;
  logic [CNT_W-1:0]      cur_cnt;
  logic [RW-1:0]         fin_idx;
  logic [TIME_BITS-1:0]  fin_t;
  logic [SW-1:0]         fin_sum;
  logic [TIME_BITS-1:0]  fin_end;
  logic [CNT_W-1:0]      fin_old;
  logic [CNT_W-1:0]      fin_cnt;
  logic [RW-1:0]         nb_idx;
  logic [CNT_W-1:0]      nb_cnt;
  logic                  out_free;
  logic                  wr_en;

  always_comb begin
    if (num_rooms == '0) begin
      n_eff = NW'(1);
    end else if (int'(num_rooms) > ROOMS) begin
      n_eff = NW'(ROOMS);
    end else begin
      n_eff = NW'(num_rooms);
    end
  end

  assign clk_base  = head.new_set ? '0 : clock_now_r;
  assign start_ext = TIME_BITS'(head.start_time);
  assign t_start   = (clk_base > start_ext) ? clk_base : start_ext;

  assign cur_free  = vld_r[didx_r] ? rd_free_r : '0;
  assign cur_cnt   = vld_r[didx_r] ? rd_cnt_r : '0;

  assign fin_idx   = found_r ? pick_r : min_idx_r;
  assign fin_t     = found_r ? t_r : min_r;
  assign fin_old   = found_r ? pick_cnt_r : min_cnt_r;
  assign fin_cnt   = (fin_old == CNT_MAX) ? fin_old : fin_old + 1'b1;
  assign fin_sum   = {1'b0, fin_t} + SW'(dur_r);
  assign fin_end   = fin_sum[TIME_BITS] ? TIME_MAX : fin_sum[TIME_BITS-1:0];

  always_comb begin
    nb_idx = best_idx_r;
    nb_cnt = best_cnt_r;
    if (fin_idx == best_idx_r || fin_cnt > best_cnt_r ||
        (fin_cnt == best_cnt_r && fin_idx < best_idx_r)) begin
      nb_idx = fin_idx;
      nb_cnt = fin_cnt;
    end
  end

  assign out_free = !out_valid_r || out_chan.ready;
  assign pop      = (state_r == S_IDLE) && !q_stat.empty;
  assign wr_en    = (state_r == S_FIN) && out_free;

  always_ff @(posedge clk) begin
    rd_free_r <= free_mem[iss_r[RW-1:0]];
    rd_cnt_r  <= cnt_mem[iss_r[RW-1:0]];
    if (wr_en) begin
      free_mem[fin_idx] <= fin_end;
      cnt_mem[fin_idx]  <= fin_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '0;
      clock_now_r <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      dv_r        <= (state_r == S_SCAN);
      out_valid_r <= wr_en || (out_valid_r && !out_chan.ready);
      case (state_r)
        S_IDLE: begin
          if (!q_stat.empty) begin
            if (head.new_set) begin
              vld_r       <= '0;
              clock_now_r <= '0;
            end
            t_r        <= t_start;
            dur_r      <= head.dur;
            n_r        <= n_eff;
            iss_r      <= '0;
            found_r    <= 1'b0;
            min_r      <= TIME_MAX;
            min_idx_r  <= '0;
            min_cnt_r  <= '0;
            best_idx_r <= '0;
            best_cnt_r <= '0;
            state_r    <= S_SCAN;
          end
        end
        S_SCAN: begin
          didx_r <= iss_r[RW-1:0];
          iss_r  <= iss_r + 1'b1;
          if (iss_r == n_r - 1'b1) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            vld_r[fin_idx]  <= 1'b1;
            clock_now_r     <= fin_t;
            out_room_r      <= ROOM_W'(fin_idx);
            out_start_r     <= OUT_TIME_W'(fin_t);
            out_end_r       <= OUT_TIME_W'(fin_end);
            out_best_room_r <= ROOM_W'(nb_idx);
            out_best_cnt_r  <= nb_cnt;
            state_r         <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (dv_r) begin
        if (!found_r && cur_free <= t_r) begin
          found_r    <= 1'b1;
          pick_r     <= didx_r;
          pick_cnt_r <= cur_cnt;
        end
        if (didx_r == '0 || cur_free < min_r) begin
          min_r     <= cur_free;
          min_idx_r <= didx_r;
          min_cnt_r <= cur_cnt;
        end
        if (didx_r == '0 || cur_cnt > best_cnt_r) begin
          best_idx_r <= didx_r;
          best_cnt_r <= cur_cnt;
        end
      end
    end
  end

  assign out_chan.valid             = out_valid_r;
  assign out_chan.room              = out_room_r;
  assign out_chan.actual_start      = out_start_r;
  assign out_chan.actual_end        = out_end_r;
  assign out_chan.most_booked_room  = out_best_room_r;
  assign out_chan.most_booked_count = out_best_cnt_r;

endmodule

`default_nettype wire

@@ rtl/lowest_free_room_allocator.sv @@
// The back end takes one item at a time and scans the room state memories
// one room per cycle; it pops no new item until its result is registered.
// The front end keeps accepting up to two items into its queue meanwhile.
// Reset: synchronous, active low; clears all room state, the clock, the
// queue and the output register; the room count returns to 16.
// ----------------------------------------------------------------------------
// lowest_free_room_allocator: top level
// Configuration register plus front end, request queue and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lowest_free_room_allocator import lfra_pkg::*; #(
  parameter int ROOMS     = 16,
  parameter int TIME_BITS = 48
) (
  input  logic        clk,
  input  logic        rst_n,
  lfra_cfg_if.sink    cfg_chan,
  lfra_in_if.sink     in_chan,
  lfra_out_if.source  out_chan
);

  logic [CFG_W-1:0] num_rooms_r;
  logic             q_push;
  logic             q_pop;
  lfra_req_t        q_in;
  lfra_req_t        q_head;
  lfra_qstat_t      q_stat;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rooms_r <= NUM_ROOMS_RST;
    end else if (cfg_chan.valid) begin
      num_rooms_r <= cfg_chan.num_rooms;
    end
  end

  lfra_front u_front (
    .in_chan (in_chan),
    .q_stat  (q_stat),
    .push    (q_push),
    .req     (q_in)
  );

  lfra_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  lfra_back #(
    .ROOMS     (ROOMS),
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .num_rooms (num_rooms_r),
    .head      (q_head),
    .q_stat    (q_stat),
    .pop       (q_pop),
    .out_chan  (out_chan)
  );

endmodule

`default_nettype wire

@@ rtl/lfra_checker.sv @@
// ----------------------------------------------------------------------------
// lfra_checker: port-level checks
// Watches the allocator ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lfra_checker import lfra_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [OUT_TIME_W-1:0] actual_start,
  input logic [OUT_TIME_W-1:0] actual_end,
  input logic [CNT_W-1:0]      most_booked_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_end_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> actual_end >= actual_start)
    else $error("booking ends before it starts");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> most_booked_count != '0)
    else $error("most booked count is zero on a result");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind lowest_free_room_allocator lfra_checker u_lfra_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_chan.ready),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .actual_start      (out_chan.actual_start),
  .actual_end        (out_chan.actual_end),
  .most_booked_count (out_chan.most_booked_count)
);

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: lowest free room allocator testbench
// Streams booking requests through the allocator under several room counts,
// runs its own room scheduler in parallel and compares every room grant,
// start, end and most-booked report with the scheduler's answer.
// ----------------------------------------------------------------------------
module tb_top;
  import lfra_pkg::*;

  localparam int ROOMS = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 24;
  localparam logic [OUT_TIME_W-1:0] TIME_MAX = {OUT_TIME_W{1'b1}};

  typedef struct {
    logic [IN_TIME_W-1:0] start_t;
    logic [IN_TIME_W-1:0] end_t;
    logic                 new_set;
  } booking_t;

  typedef struct {
    logic [ROOM_W-1:0]     room;
    logic [OUT_TIME_W-1:0] act_start;
    logic [OUT_TIME_W-1:0] act_end;
    logic [ROOM_W-1:0]     top_room;
    logic [CNT_W-1:0]      top_count;
  } grant_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lfra_cfg_if cfg_bus ();
  lfra_in_if  in_bus ();
  lfra_out_if out_bus ();

  lowest_free_room_allocator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_bus),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // scheduler state
  logic [OUT_TIME_W-1:0] room_free [ROOMS];
  logic [CNT_W-1:0]      room_uses [ROOMS];
  logic [OUT_TIME_W-1:0] sched_clock;
  logic [CFG_W-1:0]      rooms_cfg;

  booking_t booking_q[$];
  grant_t   grant_q[$];
  booking_t next_booking;
  grant_t   want_grant;

  int  items_queued = 0;
  int  items_taken = 0;
  int  grants_checked = 0;
  int  waited_bookings = 0;
  int  cfg_writes = 0;
  int  errors = 0;
  int  quiet_cycles = 0;
  int  send_gap = 0;
  int  recv_stall = 0;
  bit  send_rough = 1'b1;
  bit  recv_rough = 1'b1;
  bit  calm = 1'b0;
  bit  in_taken = 1'b0;

  function automatic void clear_rooms();
    for (int r = 0; r < ROOMS; r++) begin
      room_free[r] = '0;
      room_uses[r] = '0;
    end
    sched_clock = '0;
  endfunction

  function automatic int rooms_active(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > ROOMS) return ROOMS;
    return int'(v);
  endfunction

  function automatic grant_t allocate_room(booking_t b);
    grant_t g;
    logic [OUT_TIME_W-1:0] dur, t, earliest, fin;
    int n, pick;
    bit found;
    n = rooms_active(rooms_cfg);
    dur = (b.end_t > b.start_t) ? OUT_TIME_W'(b.end_t - b.start_t) : '0;
    if (b.new_set) clear_rooms();
    t = (sched_clock > OUT_TIME_W'(b.start_t)) ? sched_clock : OUT_TIME_W'(b.start_t);
    found = 1'b0;
    pick = 0;
    earliest = TIME_MAX;
    for (int r = 0; r < n; r++) begin
      if (!found && room_free[r] <= t) begin
        pick = r;
        found = 1'b1;
      end
      if (room_free[r] < earliest) earliest = room_free[r];
    end
    if (!found) begin
      waited_bookings++;
      t = earliest;
      for (int r = n - 1; r >= 0; r--)
        if (room_free[r] <= t) pick = r;
    end
    sched_clock = t;
    fin = (dur > TIME_MAX - t) ? TIME_MAX : t + dur;
    room_free[pick] = fin;
    if (room_uses[pick] != {CNT_W{1'b1}}) room_uses[pick] = room_uses[pick] + 1;
    g.room = ROOM_W'(pick);
    g.act_start = t;
    g.act_end = fin;
    g.top_room = '0;
    g.top_count = room_uses[0];
    for (int r = 1; r < n; r++) begin
      if (room_uses[r] > g.top_count) begin
        g.top_count = room_uses[r];
        g.top_room = ROOM_W'(r);
      end
    end
    return g;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // drive requests
  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_taken) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_bus.valid <= 1'b0;
      end else if (!calm && send_rough && $urandom_range(0, 3) == 0) begin
        send_gap <= $urandom_range(0, 4);
        in_bus.valid <= 1'b0;
      end else if (booking_q.size() != 0) begin
        next_booking = booking_q.pop_front();
        in_bus.valid <= 1'b1;
        in_bus.start_time <= next_booking.start_t;
        in_bus.end_time <= next_booking.end_t;
        in_bus.new_set <= next_booking.new_set;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
    if ($urandom_range(0, 63) == 0) send_rough <= !send_rough;
  end

  // drive result backpressure
  always @(negedge clk) begin
    if (recv_stall > 0) begin
      recv_stall <= recv_stall - 1;
      out_bus.ready <= 1'b0;
    end else if (!calm && recv_rough && $urandom_range(0, 3) == 0) begin
      recv_stall <= $urandom_range(0, 4);
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
    if ($urandom_range(0, 63) == 0) recv_rough <= !recv_rough;
  end

  // monitor, predict, check
  always @(posedge clk) begin
    in_taken <= rst_n && in_bus.valid && in_bus.ready;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        if (grant_q.size() == 0) begin
          errors++;
          $display("%0t: result with no booking outstanding, actual room %0d start %0h",
                   $time, out_bus.room, out_bus.actual_start);
        end else begin
          want_grant = grant_q.pop_front();
          check_field("room", 64'(want_grant.room), 64'(out_bus.room));
          check_field("actual_start", 64'(want_grant.act_start),
                      64'(out_bus.actual_start));
          check_field("actual_end", 64'(want_grant.act_end), 64'(out_bus.actual_end));
          check_field("most_booked_room", 64'(want_grant.top_room),
                      64'(out_bus.most_booked_room));
          check_field("most_booked_count", 64'(want_grant.top_count),
                      64'(out_bus.most_booked_count));
          grants_checked++;
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        grant_q.push_back(allocate_room('{in_bus.start_time, in_bus.end_time,
                                          in_bus.new_set}));
        items_taken++;
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        rooms_cfg = cfg_bus.num_rooms;
        cfg_writes++;
      end
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                   $time, STALL_LIMIT, grant_q.size());
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

  task automatic push_booking(logic [IN_TIME_W-1:0] s, logic [IN_TIME_W-1:0] e, logic ns);
    booking_q.push_back('{s, e, ns});
    items_queued++;
  endtask

  task automatic settle();
    do @(negedge clk); while (items_taken != items_queued || grant_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_rooms(logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.num_rooms <= v;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic queue_random(int total, logic [CFG_W-1:0] v);
    int left, span, eff;
    logic [IN_TIME_W-1:0] t, d;
    eff = rooms_active(v);
    left = total;
    while (left > 0) begin
      span = $urandom_range(1, 40);
      t = ($urandom_range(0, 4) == 0) ? IN_TIME_W'($urandom()) : $urandom_range(0, 1000);
      for (int k = 0; k < span && left > 0; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          push_booking($urandom(), $urandom(), 1'($urandom_range(0, 1)));
        end else begin
          t = t + $urandom_range(0, 8);
          d = ($urandom_range(0, 15) == 0) ? IN_TIME_W'($urandom())
                                           : $urandom_range(0, 8 * eff + 8);
          push_booking(t, t + d, k == 0);
        end
        left--;
      end
    end
  endtask

  logic [CFG_W-1:0] room_settings [9];

  initial begin
    in_bus.valid = 1'b0;
    in_bus.start_time = '0;
    in_bus.end_time = '0;
    in_bus.new_set = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.num_rooms = NUM_ROOMS_RST;
    out_bus.ready = 1'b0;
    rooms_cfg = NUM_ROOMS_RST;
    clear_rooms();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // two rooms: fill, wait, zero and huge durations, field extremes
    write_rooms(5'd2);
    push_booking(32'd0, 32'd0, 1'b1);
    push_booking(32'd0, 32'd10, 1'b0);
    push_booking(32'd1, 32'd5, 1'b0);
    push_booking(32'd2, 32'd7, 1'b0);
    push_booking(32'd3, 32'd4, 1'b0);
    push_booking(32'd3, 32'd2, 1'b0);
    push_booking(32'd100, 32'hFFFF_FFFF, 1'b0);
    push_booking(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    push_booking(32'hFFFF_FFFF, 32'd0, 1'b0);
    push_booking(32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1);
    push_booking(32'd0, 32'hFFFF_FFFF, 1'b1);
    push_booking(32'h8000_0000, 32'h8000_0001, 1'b0);
    push_booking(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
    push_booking(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
    push_booking(32'hAAAA_AAAA, 32'hAAAA_AAB0, 1'b0);
    push_booking(32'hAAAA_AAAB, 32'hAAAA_AAC0, 1'b0);
    settle();

    room_settings = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd4,
                      5'($urandom_range(0, 31)), 5'($urandom_range(1, 16)), 5'd3};
    for (int p = 0; p < 9; p++) begin
      if (p == 8) calm <= 1'b1;
      write_rooms(room_settings[p]);
      queue_random(110, room_settings[p]);
      settle();
    end

    $display("%0d bookings granted and checked over %0d room count writes",
             grants_checked, cfg_writes);
    $display("%0d bookings had to wait for a room to free up", waited_bookings);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
